[hw/rtl/bvd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvd_pkg
// Shared types, constants and helpers for the bit vector distance block.
// ----------------------------------------------------------------------------
package bvd_pkg;

    localparam int WORD_W        = 64;
    localparam int BYTE_N        = 8;
    localparam int NBYTES_W      = 4;
    localparam int DIST_W        = 17;
    localparam int POP_W         = 7;
    localparam int BVD_MAX_WORDS = 1024;
    localparam int QUEUE_DEPTH   = 2;
    localparam int Q_ONE         = 65536;

    typedef struct packed {
        logic [WORD_W-1:0]   a_word;
        logic [WORD_W-1:0]   b_word;
        logic [NBYTES_W-1:0] valid_bytes;
        logic                last_word;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] hamming_distance;
        logic [DIST_W-1:0] jaccard_distance;
    } out_item_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIV,
        BACK_DONE
    } back_state_t;

    // Keep only the low nb bytes; values above eight keep the whole word.
    function automatic logic [WORD_W-1:0] mask_bytes(
        input logic [WORD_W-1:0]   w,
        input logic [NBYTES_W-1:0] nb
    );
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < BYTE_N; i++)
        begin
            if (NBYTES_W'(i) < nb)
            begin
                m[i*8 +: 8] = w[i*8 +: 8];
            end
        end
        return m;
    endfunction

    function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

[hw/rtl/bvd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvd_front
// Masks each word pair, popcounts it and accumulates the four counts.
// On the last word the totals are pushed to the queue and the counts clear.
// ----------------------------------------------------------------------------
module bvd_front
    import bvd_pkg::*;
#(
    parameter int MAX_WORDS = BVD_MAX_WORDS,
    localparam int CNT_W    = $clog2(MAX_WORDS * 64 + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               word_valid,
    output logic               word_stall,
    input  in_item_t           word,
    input  logic               full,
    output logic               push,
    output logic [4*CNT_W-1:0] push_data
);

    localparam logic [CNT_W:0] CAP = (CNT_W + 1)'(MAX_WORDS * 64);

    logic [CNT_W-1:0]  xor_reg, and_reg, a_reg, b_reg;
    logic [CNT_W-1:0]  xor_next, and_next, a_next, b_next;
    logic [CNT_W-1:0]  sum_x, sum_and, sum_a, sum_b;
    logic [WORD_W-1:0] a_m, b_m;
    logic              accept;

    function automatic logic [CNT_W-1:0] sat_add(
        input logic [CNT_W-1:0] acc,
        input logic [POP_W-1:0] inc
    );
        logic [CNT_W:0] s;
        s = {1'b0, acc} + (CNT_W + 1)'(inc);
        return (s > CAP) ? CAP[CNT_W-1:0] : s[CNT_W-1:0];
    endfunction

    assign word_stall = full;
    assign accept     = word_valid & ~full;
    assign push       = accept & word.last_word;
    assign push_data  = {sum_x, sum_and, sum_a, sum_b};

    always_comb
    begin
        a_m     = mask_bytes(word.a_word, word.valid_bytes);
        b_m     = mask_bytes(word.b_word, word.valid_bytes);
        sum_x   = sat_add(xor_reg, popcount64(a_m ^ b_m));
        sum_and = sat_add(and_reg, popcount64(a_m & b_m));
        sum_a   = sat_add(a_reg, popcount64(a_m));
        sum_b   = sat_add(b_reg, popcount64(b_m));

        xor_next = xor_reg;
        and_next = and_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        if (accept)
        begin
            if (word.last_word)
            begin
                xor_next = '0;
                and_next = '0;
                a_next   = '0;
                b_next   = '0;
            end
            else
            begin
                xor_next = sum_x;
                and_next = sum_and;
                a_next   = sum_a;
                b_next   = sum_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg <= '0;
            and_reg <= '0;
            a_reg   <= '0;
            b_reg   <= '0;
        end
        else
        begin
            xor_reg <= xor_next;
            and_reg <= and_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
        end
    end

endmodule

[hw/rtl/bvd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvd_queue
// Short FIFO of per-vector totals between front and back.
// ----------------------------------------------------------------------------
module bvd_queue
    import bvd_pkg::*;
#(
    parameter int WIDTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[hw/rtl/bvd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvd_back
// Pops vector totals, runs a bit-serial restoring divide for the Jaccard
// ratio and holds the result in an output register.
// ----------------------------------------------------------------------------
module bvd_back
    import bvd_pkg::*;
#(
    parameter int MAX_WORDS = BVD_MAX_WORDS,
    localparam int CNT_W    = $clog2(MAX_WORDS * 64 + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  logic [4*CNT_W-1:0] pop_data,
    output logic               pop,
    output logic               dist_valid,
    input  logic               dist_stall,
    output out_item_t          distance
);

    localparam int STEP_W = $clog2(DIST_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIST_W - 1);

    back_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W+1:0]  rem_reg;
    logic [CNT_W:0]    den_reg;
    logic [DIST_W-1:0] quo_reg;
    logic [DIST_W-1:0] ham_reg;
    logic              zero_reg;
    out_item_t         out_reg;

    logic [CNT_W-1:0]  t_xor, t_and, t_a, t_b;
    logic [CNT_W:0]    den_load;
    logic              ge;
    logic [CNT_W+1:0]  diff;
    logic [DIST_W-1:0] quo_full;
    logic              load, step_en, finish;

    assign {t_xor, t_and, t_a, t_b} = pop_data;
    assign den_load = (CNT_W + 1)'(t_a) + (CNT_W + 1)'(t_b) - (CNT_W + 1)'(t_and);

    // Remainder stays below twice the divisor, so one compare per bit.
    assign ge       = (rem_reg >= {1'b0, den_reg}) & ~zero_reg;
    assign diff     = ge ? rem_reg - {1'b0, den_reg} : rem_reg;
    assign quo_full = {quo_reg[DIST_W-2:0], ge};
    assign distance = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BACK_IDLE:
            begin
                if (!empty)
                begin
                    state_next = BACK_DIV;
                end
            end
            BACK_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = BACK_DONE;
                end
            end
            BACK_DONE:
            begin
                if (!dist_stall)
                begin
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        load       = 1'b0;
        step_en    = 1'b0;
        finish     = 1'b0;
        dist_valid = 1'b0;
        case (state_reg)
            BACK_IDLE:
            begin
                load = ~empty;
            end
            BACK_DIV:
            begin
                step_en = 1'b1;
                finish  = (step_reg == LAST_STEP);
            end
            BACK_DONE:
            begin
                dist_valid = 1'b1;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        pop = load;
    end

    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            step_next = '0;
        end
        else if (step_en)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= (CNT_W + 2)'(t_and);
            den_reg  <= den_load;
            zero_reg <= (den_load == '0);
            quo_reg  <= '0;
            ham_reg  <= DIST_W'(t_xor);
        end
        else if (step_en)
        begin
            rem_reg <= {diff[CNT_W:0], 1'b0};
            quo_reg <= quo_full;
        end
        if (finish)
        begin
            out_reg.hamming_distance <= ham_reg;
            out_reg.jaccard_distance <= DIST_W'(Q_ONE) - quo_full;
        end
    end

endmodule

[hw/rtl/bit_vector_distance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_vector_distance
// Hamming and Jaccard distance of two bit vectors streamed as 64-bit words.
// ----------------------------------------------------------------------------
// The front end takes one word pair per cycle: it masks off bytes past
// valid_bytes, popcounts a^b, a&b, a and b, and adds them into counters that
// saturate at MAX_WORDS*64. A transaction with last_word set closes the
// vector; its totals go into a two-entry queue and the counters clear at once,
// so the next vector can start in the following cycle. The back end turns each
// queued set of totals into one result: hamming_distance is the XOR count
// (low 17 bits), jaccard_distance is 65536 - floor(ab*65536/(aa+bb-ab)) in
// unsigned Q1.16, 65536 when no bit is common (empty vectors included). The
// ratio comes from a restoring divider that retires one quotient bit per
// cycle; the back end loads one set of totals, divides, then holds the
// result until it is taken before it pops the next. Word throughput is one
// per cycle; the front stalls only when two finished vectors are already
// waiting, i.e. when short vectors arrive back to back or results are held.
// ----------------------------------------------------------------------------
module bit_vector_distance
    import bvd_pkg::*;
#(
    parameter int MAX_WORDS = BVD_MAX_WORDS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      word_valid,
    output logic      word_stall,
    input  in_item_t  word,
    output logic      dist_valid,
    input  logic      dist_stall,
    output out_item_t distance
);

    localparam int CNT_W = $clog2(MAX_WORDS * 64 + 1);

    logic               push, pop, full, empty;
    logic [4*CNT_W-1:0] push_data, pop_data;

    // word intake, masking, popcount and accumulation
    bvd_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word       (word),
        .full       (full),
        .push       (push),
        .push_data  (push_data)
    );

    // per-vector totals awaiting the divider
    bvd_queue #(
        .WIDTH (4 * CNT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    // Jaccard divide and result register
    bvd_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .dist_valid (dist_valid),
        .dist_stall (dist_stall),
        .distance   (distance)
    );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bit_vector_distance: streams word pairs, predicts
// the Hamming and Q1.16 Jaccard distance of every closed vector and checks
// each output transaction in order under random and forced backpressure.
// ----------------------------------------------------------------------------
module tb_top;
    import bvd_pkg::*;

    localparam int COUNT_CAP = BVD_MAX_WORDS * 64;   // every counter saturates here
    localparam int DRAIN_CYCLES = 40;                // longer than one back end load, divide and output

    logic      clk = 1'b0;
    logic      rst_n;
    logic      word_valid;
    logic      word_stall;
    in_item_t  word;
    logic      dist_valid;
    logic      dist_stall = 1'b0;
    out_item_t distance;

    bit_vector_distance u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word       (word),
        .dist_valid (dist_valid),
        .dist_stall (dist_stall),
        .distance   (distance)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shared state: running popcounts of the open vector, the queue of
    // distances still owed by the DUT, and a few run statistics.
    // ------------------------------------------------------------------
    int xor_ones;
    int and_ones;
    int a_ones;
    int b_ones;

    out_item_t expected_dists[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold_left = 0;

    int errors = 0;
    int words_sent = 0;
    int dists_checked = 0;
    int front_stall_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d, t=%0t)",
                 what, got, want, dists_checked, $time);
        errors++;
    endtask

    function automatic int sat_count(input int n);
        return (n > COUNT_CAP) ? COUNT_CAP : n;
    endfunction

    // Fold one accepted word transaction into the open vector; on the last
    // word close the vector and queue the distance pair it must produce.
    function automatic void absorb_word(input in_item_t w);
        logic [WORD_W-1:0] keep;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        longint            denom;
        longint            ratio;
        out_item_t         d;
        int                nb;
        nb = int'(w.valid_bytes);
        // counts above eight bytes keep the whole word
        keep = (nb >= BYTE_N) ? '1 : ((64'd1 << (nb * 8)) - 64'd1);
        a = w.a_word & keep;
        b = w.b_word & keep;
        xor_ones = sat_count(xor_ones + $countones(a ^ b));
        and_ones = sat_count(and_ones + $countones(a & b));
        a_ones   = sat_count(a_ones + $countones(a));
        b_ones   = sat_count(b_ones + $countones(b));
        if (w.last_word)
        begin
            denom = longint'(a_ones) + longint'(b_ones) - longint'(and_ones);
            // nothing in common (empty vectors too) -> distance 1.0
            if (and_ones == 0 || denom == 0 || longint'(and_ones) > denom)
                ratio = Q_ONE;
            else
                ratio = Q_ONE - (longint'(and_ones) * Q_ONE) / denom;
            d.hamming_distance = DIST_W'(xor_ones);
            d.jaccard_distance = DIST_W'(ratio);
            expected_dists.push_back(d);
            xor_ones = 0;
            and_ones = 0;
            a_ones   = 0;
            b_ones   = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: drive at the falling edge, look for acceptance at the
    // rising edge. Random gaps come before the transaction is offered;
    // once offered it is held until the DUT takes it.
    // ------------------------------------------------------------------
    task automatic send_word(input in_item_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            word_valid = 1'b0;
            @(negedge clk);
        end
        word       = w;
        word_valid = 1'b1;
        @(posedge clk);
        while (word_stall)
        begin
            front_stall_cycles++;
            @(posedge clk);
        end
        absorb_word(w);
        words_sent++;
    endtask

    task automatic send_pair(input logic [63:0] a, input logic [63:0] b,
                             input int nb, input bit last);
        in_item_t w;
        w.a_word      = a;
        w.b_word      = b;
        w.valid_bytes = NBYTES_W'(nb);
        w.last_word   = last;
        send_word(w);
    endtask

    // Random word with a chosen bit density: plain, sparse or dense.
    function automatic logic [63:0] rand_bits(input int density);
        logic [63:0] r;
        r = {$urandom, $urandom};
        case (density)
            1: r = r & {$urandom, $urandom} & {$urandom, $urandom};
            2: r = r | {$urandom, $urandom} | {$urandom, $urandom};
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_random_vector(input int len);
        logic [63:0] a;
        logic [63:0] b;
        int          nb;
        int          shape;
        for (int i = 0; i < len; i++)
        begin
            a = rand_bits($urandom_range(2));
            shape = $urandom_range(5);
            case (shape)
                0: b = a;                  // identical words
                1: b = ~a;                 // disjoint words
                default: b = rand_bits($urandom_range(2));
            endcase
            // mostly full words, the rest any byte count including > 8
            nb = ($urandom_range(9) < 6) ? BYTE_N : $urandom_range(15);
            send_pair(a, b, nb, i == len - 1);
        end
    endtask

    // Wait until every owed result has come back, then let the back end
    // settle; the global watchdog bounds this wait.
    task automatic wait_drain();
        @(negedge clk);
        word_valid = 1'b0;
        while (expected_dists.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall at random, or for a forced stretch when a test
    // loads recv_hold_left.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (recv_hold_left > 0)
        begin
            dist_stall = 1'b1;
            recv_hold_left = recv_hold_left - 1;
        end
        else
        begin
            dist_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker: every output transaction against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && dist_valid && !dist_stall)
        begin
            if (expected_dists.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                if (distance.hamming_distance !== expected_dists[0].hamming_distance)
                    report_mismatch("hamming_distance", int'(distance.hamming_distance),
                                    int'(expected_dists[0].hamming_distance));
                if (distance.jaccard_distance !== expected_dists[0].jaccard_distance)
                    report_mismatch("jaccard_distance", int'(distance.jaccard_distance),
                                    int'(expected_dists[0].jaccard_distance));
                void'(expected_dists.pop_front());
            end
            dists_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked vectors: extremes, byte masking, empty vectors.
    task automatic test_directed();
        send_pair('0, '0, 0, 1'b1);                       // empty vector -> 1.0
        send_pair('1, '1, 0, 1'b1);                       // all masked off
        send_pair('1, '1, 8, 1'b1);                       // identical -> 0.0
        send_pair('1, '0, 8, 1'b1);                       // disjoint, 64 differ
        send_pair('0, '0, 8, 1'b1);                       // all zero, full bytes
        send_pair('1, '1, 15, 1'b1);                      // byte count over 8
        send_pair('1, 64'h0F0F_0F0F_0F0F_0F0F, 9, 1'b1);
        for (int nb = 1; nb < BYTE_N; nb++)               // each partial mask
            send_pair('1, 64'hAAAA_AAAA_AAAA_AAAA, nb, 1'b1);
        send_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 8, 1'b1);
        // multi-word vector; inner words do not close it
        send_pair(64'hFFFF_0000_FFFF_0000, 64'hFFFF_FFFF_0000_0000, 8, 1'b0);
        send_pair('1, '1, 0, 1'b0);
        send_pair(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0003, 8, 1'b0);
        send_pair(64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321, 3, 1'b1);
        send_pair(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001, 1, 1'b1);
        wait_drain();
    endtask

    // One vector longer than MAX_WORDS: the and, a and b counters hit their
    // ceiling; the closing words are disjoint so xor picks up a count too.
    task automatic test_saturation();
        int len;
        len = BVD_MAX_WORDS + 6;
        for (int i = 0; i < len; i++)
        begin
            if (i < len - 2)
                send_pair('1, '1, 8, 1'b0);
            else
                send_pair('1, '0, 8, i == len - 1);
        end
        wait_drain();
    endtask

    // Long receiver hold while short vectors keep coming: the queue of totals
    // fills and the front end must push back.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        recv_hold_left = 300;
        for (int i = 0; i < 30; i++)
            send_random_vector(1);
        wait_drain();
    endtask

    // Random vectors, mostly short, now and then a few dozen words.
    task automatic test_random_traffic(input int n_words, input int s_idle, input int r_idle);
        int start;
        int len;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        start = words_sent;
        while (words_sent - start < n_words)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            send_random_vector(len);
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        word_valid = 1'b0;
        word       = '0;
        xor_ones   = 0;
        and_ones   = 0;
        a_ones     = 0;
        b_ones     = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_saturation();
        test_backpressure();
        test_random_traffic(90, 22, 81);
        test_random_traffic(90, 81, 22);
        test_random_traffic(90, 0, 0);

        $display("Covered %0d word transactions and %0d distance results,",
                 words_sent, dists_checked);
        $display("counter saturation and %0d cycles of input pushback.",
                 front_stall_cycles);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results still owed", expected_dists.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
